>>> rtl/dbd_pkg.sv
// package: payload types, calendar tables and constant-divisor helpers for the date difference block
`timescale 1ns / 1ps
package dbd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  // quotient widths for the leap count terms
  localparam int unsigned Q100W  = 8;
  localparam int unsigned Q400W  = 6;

  localparam logic [YearW-1:0]  YearMax   = 14'd9999;
  localparam logic [MonthW-1:0] MonthJan  = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonthDec  = 4'd12;
  localparam logic [DayW-1:0]   LeapFebLen = 5'd29;

  // floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned DivArgW     = 15;
  localparam int unsigned DivProdW    = 28;

  typedef struct packed {
    logic [YearW-1:0]  first_year;
    logic [MonthW-1:0] first_month;
    logic [DayW-1:0]   first_day;
    logic [YearW-1:0]  second_year;
    logic [MonthW-1:0] second_month;
    logic [DayW-1:0]   second_day;
  } dbd_in_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              dates_valid;
  } dbd_out_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } dbd_date_t;

  // day number of one date and its validity
  typedef struct packed {
    logic [CountW-1:0] num;
    logic              ok;
  } dbd_day_t;

  // stage load strobes shared by both lanes
  typedef struct packed {
    logic ld1;
    logic ld2;
  } dbd_lane_ctl_t;

  function automatic logic [8:0] div100(input logic [DivArgW-1:0] x);
    logic [DivProdW-1:0] prod;
    prod = DivProdW'(x) * DivProdW'(Div100Mul);
    return prod[Div100Shift +: 9];
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:    len = leap ? LeapFebLen : 5'd28;
      default: len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/days_between_dates.sv
// top level: absolute day count between two gregorian dates, two date lanes and a merge stage
// throughput: one date pair per cycle while the output is not stalled by out_ready_i;
// every stage loads as soon as its own slot is free
// stages: lane quotient stage, lane day-number stage, merge/output register
// reset: async active low, clears the stage valid bits only; datapath registers are not reset
`timescale 1ns / 1ps
module days_between_dates
  import dbd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dbd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dbd_out_t out_data_o
);

  // valid bits of the two lane stages, kept once here for both lanes
  logic v1_q, v2_q;
  logic s1_free, s2_free, s3_free;
  dbd_lane_ctl_t ctl;

  // a stage may load when it is empty or its beat moves on in the same cycle
  assign s2_free    = !v2_q || s3_free;
  assign s1_free    = !v1_q || s2_free;
  assign in_ready_o = s1_free;

  assign ctl.ld1 = in_valid_i && s1_free;
  assign ctl.ld2 = v1_q && s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_q <= in_valid_i;
      end
      if (s2_free) begin
        v2_q <= v1_q;
      end
    end
  end

  // split the input beat into one date per lane
  dbd_date_t date_a, date_b;
  dbd_day_t  day_a, day_b;

  assign date_a.year  = in_data_i.first_year;
  assign date_a.month = in_data_i.first_month;
  assign date_a.day   = in_data_i.first_day;
  assign date_b.year  = in_data_i.second_year;
  assign date_b.month = in_data_i.second_month;
  assign date_b.day   = in_data_i.second_day;

  // lane for the first date
  dbd_lane u_lane_a (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .date_i (date_a),
    .res_o  (day_a)
  );

  // lane for the second date
  dbd_lane u_lane_b (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .date_i (date_b),
    .res_o  (day_b)
  );

  // difference, validity merge and output register
  dbd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_ready_o  (s3_free),
    .first_i     (day_a),
    .second_i    (day_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/dbd_lane.sv
// one date lane: validity check and day number from year 0, in two register stages
`timescale 1ns / 1ps
module dbd_lane
  import dbd_pkg::*;
(
  input  logic          clk_i,
  input  dbd_lane_ctl_t ctl_i,
  input  dbd_date_t     date_i,
  output dbd_day_t      res_o
);

  // stage 1: date plus the quotient for the leap rule and the two quotients of the leap count
  dbd_date_t        date_q;
  logic [Q100W-1:0] qy_q, qa_q;
  logic [Q400W-1:0] qb_q;
  logic [Q100W-1:0] qy_d, qa_d;
  logic [Q400W-1:0] qb_d;

  logic [DivArgW-1:0] y_ext, ya, yb;

  always_comb begin
    y_ext = DivArgW'(date_i.year);
    ya    = y_ext + DivArgW'(99);
    yb    = y_ext + DivArgW'(399);
    qy_d  = Q100W'(div100(y_ext));
    qa_d  = Q100W'(div100(ya));
    qb_d  = Q400W'(div100(DivArgW'(yb >> 2)));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld1) begin
      date_q <= date_i;
      qy_q   <= qy_d;
      qa_q   <= qa_d;
      qb_q   <= qb_d;
    end
  end

  // stage 2: leap rule, range checks and the closed form
  logic [YearW-1:0]  rem100;
  logic              leap;
  logic [YearW-1:0]  leaps;
  logic [DayW-1:0]   mlen;
  logic              ok_d;
  logic [CountW-1:0] num_d;
  dbd_day_t          res_q;

  always_comb begin
    rem100 = date_q.year - YearW'(qy_q) * YearW'(100);
    leap   = (date_q.year[1:0] == 2'b00) && ((rem100 != '0) || (qy_q[1:0] == 2'b00));
    leaps  = YearW'((DivArgW'(date_q.year) + DivArgW'(3)) >> 2) - YearW'(qa_q) + YearW'(qb_q);
    mlen   = month_len(date_q.month, leap);
    ok_d   = (date_q.year <= YearMax) && (date_q.month >= MonthJan) &&
             (date_q.month <= MonthDec) && (date_q.day != '0) && (date_q.day <= mlen);
    num_d  = CountW'(date_q.year) * CountW'(365) + CountW'(leaps) +
             CountW'(days_before(date_q.month)) + CountW'(date_q.day) +
             CountW'((date_q.month > MonthFeb) && leap);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      res_q.num <= num_d;
      res_q.ok  <= ok_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/dbd_merge.sv
// merge stage: absolute difference of the two day numbers into the output register
`timescale 1ns / 1ps
module dbd_merge
  import dbd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dbd_day_t first_i,
  input  dbd_day_t second_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dbd_out_t out_data_o
);

  logic     valid_q;
  dbd_out_t data_q, data_d;
  logic     free;

  assign free       = !valid_q || out_ready_i;
  assign in_ready_o = free;

  always_comb begin
    if (first_i.ok && second_i.ok) begin
      data_d.day_count   = (first_i.num > second_i.num) ? (first_i.num - second_i.num)
                                                        : (second_i.num - first_i.num);
      data_d.dates_valid = 1'b1;
    end else begin
      data_d.day_count   = '0;
      data_d.dates_valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> sim/tb_days_between_dates.sv
// testbench: random and directed date pairs checked against a day-gap predictor
`timescale 1ns / 1ps
module tb_days_between_dates;
  import dbd_pkg::*;

  // one pair beat waiting for the driver; drain holds it back until every result is in
  typedef struct packed {
    dbd_in_t pair;
    logic    drain;
  } pair_beat_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  dbd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  dbd_out_t out_data;

  pair_beat_t  pair_q[$];      // pairs not yet offered to the block
  dbd_out_t    gap_want_q[$];  // predicted results, oldest first
  dbd_out_t    gap_head;
  int unsigned err_cnt    = 0;
  int unsigned beats_sent = 0;
  bit          in_taken   = 1'b0;

  // stretch of the run with no random idling on either side
  wire calm = (beats_sent >= 400) && (beats_sent < 550);

  days_between_dates u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------

  // gregorian rule, year 0 counts as leap
  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // length of month m, 0 for a month number outside 1..12
  function automatic int unsigned month_days(int unsigned m, bit leap);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // days in the months ahead of m in a common year
  function automatic int unsigned days_ahead(int unsigned m);
    case (m)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
    return (y <= 9999) && (d >= 1) && (d <= month_days(m, leap_year(y)));
  endfunction

  // running day number with 0000-01-01 as day 1
  function automatic int unsigned day_index(int unsigned y, int unsigned m, int unsigned d);
    int unsigned leaps;
    int unsigned n;
    leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    n = 365 * y + leaps + days_ahead(m) + d;
    if (m > 2 && leap_year(y)) n = n + 1;
    return n;
  endfunction

  function automatic dbd_out_t calc_day_gap(dbd_in_t p);
    dbd_out_t    res;
    int unsigned a;
    int unsigned b;
    res = '0;
    if (date_ok(32'(p.first_year), 32'(p.first_month), 32'(p.first_day)) &&
        date_ok(32'(p.second_year), 32'(p.second_month), 32'(p.second_day))) begin
      a = day_index(32'(p.first_year), 32'(p.first_month), 32'(p.first_day));
      b = day_index(32'(p.second_year), 32'(p.second_month), 32'(p.second_day));
      res.day_count   = CountW'((a > b) ? (a - b) : (b - a));
      res.dates_valid = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_pair(int unsigned y1, int unsigned m1, int unsigned d1,
                          int unsigned y2, int unsigned m2, int unsigned d2,
                          bit drain = 1'b0);
    pair_beat_t pb;
    pb.pair.first_year   = YearW'(y1);
    pb.pair.first_month  = MonthW'(m1);
    pb.pair.first_day    = DayW'(d1);
    pb.pair.second_year  = YearW'(y2);
    pb.pair.second_month = MonthW'(m2);
    pb.pair.second_day   = DayW'(d2);
    pb.drain             = drain;
    pair_q.push_back(pb);
  endtask

  // mostly well-formed dates, some on month and century edges, some raw noise
  function automatic dbd_date_t rand_date();
    dbd_date_t   dt;
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      dt.year  = YearW'($urandom_range(0, 9999));
      dt.month = MonthW'($urandom_range(1, 12));
      len      = month_days(32'(dt.month), leap_year(32'(dt.year)));
      dt.day   = DayW'($urandom_range(1, len));
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       dt.year = '0;
        1:       dt.year = YearMax;
        2:       dt.year = YearW'(100 * $urandom_range(0, 99));
        default: dt.year = YearW'(4 * $urandom_range(0, 2499));
      endcase
      dt.month = MonthW'($urandom_range(1, 12));
      len      = month_days(32'(dt.month), leap_year(32'(dt.year)));
      // first day, last day, or one past the end
      case ($urandom_range(0, 2))
        0:       dt.day = 5'd1;
        1:       dt.day = DayW'(len);
        default: dt.day = DayW'(len + 1);
      endcase
    end else if (r < 90) begin
      // february around the leap day
      dt.year  = YearW'($urandom_range(0, 9999));
      dt.month = MonthFeb;
      dt.day   = DayW'($urandom_range(28, 30));
    end else begin
      dt.year  = YearW'($urandom);
      dt.month = MonthW'($urandom);
      dt.day   = DayW'($urandom);
    end
    return dt;
  endfunction

  task automatic report_mismatch(string what, logic [CountW-1:0] got, logic [CountW-1:0] want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 32);
      // a beat still waiting for ready stays put
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (pair_q.size() == 0 ||
            (pair_q[0].drain && gap_want_q.size() != 0) ||
            (!calm && $urandom_range(0, 99) < 32)) begin
          in_valid <= 1'b0;
        end else begin
          in_data  <= pair_q[0].pair;
          in_valid <= 1'b1;
          pair_q.pop_front();
          beats_sent++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (gap_want_q.size() == 0) begin
          report_mismatch("result beat with no pair pending", out_data.day_count, '0);
        end else begin
          gap_head = gap_want_q.pop_front();
          if (out_data.day_count !== gap_head.day_count)
            report_mismatch("day_count", out_data.day_count, gap_head.day_count);
          if (out_data.dates_valid !== gap_head.dates_valid)
            report_mismatch("dates_valid", CountW'(out_data.dates_valid),
                            CountW'(gap_head.dates_valid));
        end
      end
      // predict at acceptance; results come from a registered output, never in the accepting cycle, so order is safe
      if (in_valid && in_ready) begin
        gap_want_q.push_back(calc_day_gap(in_data));
        in_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed pairs, random pairs, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    dbd_date_t a;
    dbd_date_t b;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;

    // widest span and its mirror
    add_pair(0, 1, 1, 9999, 12, 31);
    add_pair(9999, 12, 31, 0, 1, 1);
    // same date twice
    add_pair(2024, 2, 29, 2024, 2, 29);
    // leap days: 400-rule century, plain century, ordinary years, year zero
    add_pair(2000, 2, 29, 1999, 3, 1);
    add_pair(1900, 2, 29, 1900, 3, 1);
    add_pair(2023, 2, 29, 2023, 3, 1);
    add_pair(0, 2, 29, 0, 3, 1);
    add_pair(2024, 2, 28, 2024, 3, 1);
    add_pair(9999, 2, 28, 9999, 3, 1);
    // year past the top, all-ones fields
    add_pair(10000, 1, 1, 2000, 1, 1, 1'b1);
    add_pair(2000, 1, 1, 16383, 15, 31);
    add_pair(16383, 15, 31, 16383, 15, 31);
    // bad months
    add_pair(2000, 0, 10, 2001, 1, 1);
    add_pair(2001, 1, 1, 2000, 13, 10);
    add_pair(2000, 15, 1, 2000, 1, 1);
    // bad days and month ends
    add_pair(2000, 5, 0, 2000, 5, 1);
    add_pair(2000, 4, 31, 2000, 4, 30);
    add_pair(2000, 1, 31, 2000, 12, 31);
    add_pair(1999, 12, 31, 2000, 1, 1);
    add_pair(0, 0, 0, 0, 0, 0);

    for (int i = 0; i < 1000; i++) begin
      a = rand_date();
      b = rand_date();
      if ($urandom_range(0, 4) == 0) b.year = a.year;
      add_pair(32'(a.year), 32'(a.month), 32'(a.day), 32'(b.year), 32'(b.month),
               32'(b.day), (i % 250) == 249);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every pair sent and every predicted result seen
    do begin
      @(posedge clk);
    end while (pair_q.size() != 0 || in_valid || gap_want_q.size() != 0);
    // then keep clocking to catch a stray result beat
    repeat (12) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard, far past the slowest legal run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
